// ===== rtl/sspf_pkg.sv =====
// Shared constants and types for the SPI slave start-byte packet framer.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package sspf_pkg;

	// Packet and buffer sizes.
	localparam int COMMAND_LENGTH   = 128;
	localparam int TELEMETRY_LENGTH = 512;
	localparam int BUF_DEPTH        = 512;

	// Field widths.
	localparam int BYTE_W     = 8;
	localparam int CMD_IDX_W  = 7;
	localparam int BUF_ADDR_W = $clog2(BUF_DEPTH);
	localparam int RX_POS_W   = (COMMAND_LENGTH > 1) ? $clog2(COMMAND_LENGTH) : 1;
	localparam int TX_POS_W   = (TELEMETRY_LENGTH > 1) ? $clog2(TELEMETRY_LENGTH) : 1;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RX_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TX_CODE = 2'd1;

	localparam logic [BYTE_W-1:0] RX_CODE_RST = 8'h69;
	localparam logic [BYTE_W-1:0] TX_CODE_RST = 8'h42;

	// Request operation codes.
	localparam logic OP_SPI  = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RX   = 2'd1,
		MODE_TX   = 2'd2
	} mode_t;

endpackage

`default_nettype wire

// ===== rtl/sspf_tlm_buf.sv =====
// Telemetry buffer: one write port, one read port with registered read data.
// Depends on sspf_pkg for depth and widths.
`default_nettype none

module sspf_tlm_buf (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic [sspf_pkg::BUF_ADDR_W-1:0] wr_addr,
	input  wire logic [sspf_pkg::BYTE_W-1:0]     wr_data,
	input  wire logic                            rd_en,
	input  wire logic [sspf_pkg::BUF_ADDR_W-1:0] rd_addr,
	output logic      [sspf_pkg::BYTE_W-1:0]     rd_data
);

	logic [sspf_pkg::BYTE_W-1:0] mem_q [sspf_pkg::BUF_DEPTH];
	logic [sspf_pkg::BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/spi_slave_start_byte_packet_framer.sv =====
// Top level of the SPI slave start-byte packet framer: framing state, result register.
// Depends on sspf_pkg and sspf_tlm_buf.
`default_nettype none

// Channel    Handshake             Payload
// ---------  --------------------  ----------------------------------------------
// request    in_valid / in_ready   operation, first_of_transfer, data_byte,
//                                  load_index
// result     out_valid / out_ready reply_valid, reply_byte, command_valid,
//                                  command_index, command_byte, packet_done,
//                                  framer_mode
// config     cfg_we (no wait)      cfg_index, cfg_data
//
// The framing logic works straight off the request ports and its answer lands in
// the result register at the accepting edge, together with the telemetry byte
// read from the buffer's registered read port, so the result is offered in the
// cycle after acceptance.
// A new request is accepted every cycle while the result register is empty or
// being drained in the same cycle; a stalled result holds the request channel.
// Reset idles the framer, clears both positions and restores the default start
// codes; the buffer is undefined until loaded.

module spi_slave_start_byte_packet_framer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 operation,
	input  wire logic                                 first_of_transfer,
	input  wire logic [sspf_pkg::BYTE_W-1:0]          data_byte,
	input  wire logic [sspf_pkg::BUF_ADDR_W-1:0]      load_index,

	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      reply_valid,
	output logic      [sspf_pkg::BYTE_W-1:0]          reply_byte,
	output logic                                      command_valid,
	output logic      [sspf_pkg::CMD_IDX_W-1:0]       command_index,
	output logic      [sspf_pkg::BYTE_W-1:0]          command_byte,
	output logic                                      packet_done,
	output logic      [1:0]                           framer_mode,

	input  wire logic                                 cfg_we,
	input  wire logic [sspf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sspf_pkg::BYTE_W-1:0]          cfg_data
);

	localparam logic [sspf_pkg::RX_POS_W-1:0] RX_LAST =
		sspf_pkg::RX_POS_W'(sspf_pkg::COMMAND_LENGTH - 1);
	localparam logic [sspf_pkg::TX_POS_W-1:0] TX_LAST =
		sspf_pkg::TX_POS_W'(sspf_pkg::TELEMETRY_LENGTH - 1);

	// Configuration registers.
	logic [sspf_pkg::BYTE_W-1:0] rx_code_q;
	logic [sspf_pkg::BYTE_W-1:0] tx_code_q;

	// Framing state.
	sspf_pkg::mode_t             mode_q;
	logic [sspf_pkg::RX_POS_W-1:0] rx_pos_q;
	logic [sspf_pkg::TX_POS_W-1:0] tx_pos_q;

	// Result register.
	logic                            out_valid_q;
	logic                            reply_valid_q;
	logic                            command_valid_q;
	logic [sspf_pkg::CMD_IDX_W-1:0]  command_index_q;
	logic [sspf_pkg::BYTE_W-1:0]     command_byte_q;
	logic                            packet_done_q;
	sspf_pkg::mode_t                 framer_mode_q;

	// Next-state logic.
	logic                            accept;
	sspf_pkg::mode_t                 mode_d;
	logic [sspf_pkg::RX_POS_W-1:0]   rx_pos_d;
	logic [sspf_pkg::TX_POS_W-1:0]   tx_pos_d;
	logic [sspf_pkg::RX_POS_W-1:0]   rx_pos_eff;
	logic [sspf_pkg::TX_POS_W-1:0]   tx_pos_eff;
	logic                            cmd_valid_d;
	logic                            done_d;
	logic                            reply_valid_d;
	logic [sspf_pkg::CMD_IDX_W+sspf_pkg::RX_POS_W-1:0]  rx_pos_ext;
	logic [sspf_pkg::BUF_ADDR_W+sspf_pkg::TX_POS_W-1:0] tx_pos_ext;
	logic [sspf_pkg::BYTE_W-1:0]     buf_rd_data;

	// Take a new request whenever the result register is free or drains now.
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		mode_d        = mode_q;
		rx_pos_eff    = rx_pos_q;
		tx_pos_eff    = tx_pos_q;
		cmd_valid_d   = 1'b0;
		done_d        = 1'b0;
		reply_valid_d = 1'b0;

		if (operation == sspf_pkg::OP_SPI) begin
			// The first byte of a transfer picks the mode; receive wins a tie.
			if (first_of_transfer) begin
				if (data_byte == rx_code_q) begin
					mode_d     = sspf_pkg::MODE_RX;
					rx_pos_eff = '0;
				end else if (data_byte == tx_code_q) begin
					mode_d     = sspf_pkg::MODE_TX;
					tx_pos_eff = '0;
				end else begin
					mode_d     = sspf_pkg::MODE_IDLE;
					rx_pos_eff = '0;
					tx_pos_eff = '0;
				end
			end
		end

		rx_pos_d = rx_pos_eff;
		tx_pos_d = tx_pos_eff;

		if (operation == sspf_pkg::OP_SPI) begin
			unique case (mode_d)
				sspf_pkg::MODE_RX: begin
					cmd_valid_d = 1'b1;
					if (rx_pos_eff == RX_LAST) begin
						done_d   = 1'b1;
						mode_d   = sspf_pkg::MODE_IDLE;
						rx_pos_d = '0;
					end else begin
						rx_pos_d = rx_pos_eff + 1'b1;
					end
				end
				sspf_pkg::MODE_TX: begin
					reply_valid_d = 1'b1;
					if (tx_pos_eff == TX_LAST) begin
						mode_d   = sspf_pkg::MODE_IDLE;
						tx_pos_d = '0;
					end else begin
						tx_pos_d = tx_pos_eff + 1'b1;
					end
				end
				sspf_pkg::MODE_IDLE: begin
					// Continuation byte while idle: drop it.
				end
				default: begin
					mode_d = sspf_pkg::MODE_IDLE;
				end
			endcase
		end

		// Zero-extend the positions before taking the low bits.
		rx_pos_ext = {{sspf_pkg::CMD_IDX_W{1'b0}}, rx_pos_eff};
		tx_pos_ext = {{sspf_pkg::BUF_ADDR_W{1'b0}}, tx_pos_eff};
	end

	// Loads and readouts share the buffer; each request uses at most one port.
	sspf_tlm_buf u_tlm_buf (
		.clk     (clk),
		.wr_en   (accept && (operation == sspf_pkg::OP_LOAD)),
		.wr_addr (load_index),
		.wr_data (data_byte),
		.rd_en   (accept && reply_valid_d),
		.rd_addr (tx_pos_ext[sspf_pkg::BUF_ADDR_W-1:0]),
		.rd_data (buf_rd_data)
	);

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_code_q <= sspf_pkg::RX_CODE_RST;
			tx_code_q <= sspf_pkg::TX_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sspf_pkg::REG_RX_CODE: rx_code_q <= cfg_data;
				sspf_pkg::REG_TX_CODE: tx_code_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Framing state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= sspf_pkg::MODE_IDLE;
			rx_pos_q    <= '0;
			tx_pos_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q      <= mode_d;
				rx_pos_q    <= rx_pos_d;
				tx_pos_q    <= tx_pos_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload: hold while stalled, load on accept.
	always_ff @(posedge clk) begin
		if (accept) begin
			reply_valid_q   <= reply_valid_d;
			command_valid_q <= cmd_valid_d;
			command_index_q <= cmd_valid_d ? rx_pos_ext[sspf_pkg::CMD_IDX_W-1:0] : '0;
			command_byte_q  <= cmd_valid_d ? data_byte : '0;
			packet_done_q   <= done_d;
			framer_mode_q   <= mode_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign reply_valid   = reply_valid_q;
	assign reply_byte    = reply_valid_q ? buf_rd_data : '0;
	assign command_valid = command_valid_q;
	assign command_index = command_index_q;
	assign command_byte  = command_byte_q;
	assign packet_done   = packet_done_q;
	assign framer_mode   = framer_mode_q;

endmodule

`default_nettype wire

// ===== dv/framing_scoreboard_pkg.sv =====
// Scoreboard for the SPI slave start-byte framer: mirrors start codes, mode, positions and the
// telemetry buffer, predicts one result per request and checks the block's results against them.
// Depends on sspf_pkg for widths, codes and the mode enum.
`timescale 1ns / 1ps

package framing_scoreboard_pkg;
	import sspf_pkg::*;

	typedef struct packed {
		logic                  op;
		logic                  first;
		logic [BYTE_W-1:0]     data;
		logic [BUF_ADDR_W-1:0] load_index;
	} framer_request_t;

	typedef struct packed {
		logic                 reply_valid;
		logic [BYTE_W-1:0]    reply_byte;
		logic                 command_valid;
		logic [CMD_IDX_W-1:0] command_index;
		logic [BYTE_W-1:0]    command_byte;
		logic                 packet_done;
		logic [1:0]           framer_mode;
	} framer_result_t;

	class framing_scoreboard;
		logic [BYTE_W-1:0] rx_code;
		logic [BYTE_W-1:0] tx_code;
		mode_t             mode;
		int unsigned       rx_pos;
		int unsigned       tx_pos;
		logic [BYTE_W-1:0] tlm_buf [BUF_DEPTH];
		bit                loaded [BUF_DEPTH];
		framer_result_t    framing_results_q [$];

		int n_requests, n_loads, n_results, n_commands, n_packets, n_replies, n_readouts;
		int n_errors;

		function new();
			rx_code = RX_CODE_RST;
			tx_code = TX_CODE_RST;
			mode = MODE_IDLE;
			rx_pos = 0;
			tx_pos = 0;
			foreach (loaded[i]) loaded[i] = 1'b0;
		endfunction

		function void set_code(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
			if (index == REG_RX_CODE) rx_code = value;
			else if (index == REG_TX_CODE) tx_code = value;
		endfunction

		// Buffer slot that this request would read, or -1 when it reads nothing.
		function int readout_slot(framer_request_t rq);
			mode_t       m;
			int unsigned pos;
			m = mode;
			pos = tx_pos;
			if (rq.op == OP_LOAD) return -1;
			if (rq.first) begin
				if (rq.data == rx_code) m = MODE_RX;
				else if (rq.data == tx_code) begin
					m = MODE_TX;
					pos = 0;
				end else m = MODE_IDLE;
			end
			if (m != MODE_TX) return -1;
			return int'(pos % BUF_DEPTH);
		endfunction

		function void predict_framing(framer_request_t rq);
			framer_result_t r;
			r = '0;
			n_requests++;
			if (rq.op == OP_LOAD) begin
				tlm_buf[rq.load_index] = rq.data;
				loaded[rq.load_index] = 1'b1;
				n_loads++;
			end else begin
				if (rq.first) begin
					if (rq.data == rx_code) begin
						mode = MODE_RX;
						rx_pos = 0;
					end else if (rq.data == tx_code) begin
						mode = MODE_TX;
						tx_pos = 0;
					end else begin
						mode = MODE_IDLE;
						rx_pos = 0;
						tx_pos = 0;
					end
				end
				if (mode == MODE_RX) begin
					r.command_valid = 1'b1;
					r.command_index = rx_pos[CMD_IDX_W-1:0];
					r.command_byte = rq.data;
					rx_pos++;
					n_commands++;
					if (rx_pos >= COMMAND_LENGTH) begin
						r.packet_done = 1'b1;
						mode = MODE_IDLE;
						rx_pos = 0;
						n_packets++;
					end
				end
				if (mode == MODE_TX) begin
					r.reply_valid = 1'b1;
					r.reply_byte = tlm_buf[tx_pos % BUF_DEPTH];
					tx_pos++;
					n_replies++;
					if (tx_pos >= TELEMETRY_LENGTH) begin
						mode = MODE_IDLE;
						tx_pos = 0;
						n_readouts++;
					end
				end
			end
			r.framer_mode = mode;
			framing_results_q.push_back(r);
		endfunction

		function void check_result(framer_result_t got);
			framer_result_t want;
			string          bad;
			n_results++;
			if (framing_results_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("[%0t] unexpected result %0d: %p", $time, n_results, got);
				return;
			end
			want = framing_results_q.pop_front();
			bad = "";
			if (got.reply_valid !== want.reply_valid) bad = {bad, " reply_valid"};
			if (got.reply_byte !== want.reply_byte) bad = {bad, " reply_byte"};
			if (got.command_valid !== want.command_valid) bad = {bad, " command_valid"};
			if (got.command_index !== want.command_index) bad = {bad, " command_index"};
			if (got.command_byte !== want.command_byte) bad = {bad, " command_byte"};
			if (got.packet_done !== want.packet_done) bad = {bad, " packet_done"};
			if (got.framer_mode !== want.framer_mode) bad = {bad, " framer_mode"};
			if (bad != "") begin
				n_errors++;
				if (n_errors <= 10) begin
					$display("[%0t] mismatch on result %0d, wrong:%s", $time, n_results, bad);
					$display("    expected rv=%0d rb=%h cv=%0d ci=%0d cb=%h done=%0d mode=%0d",
						want.reply_valid, want.reply_byte, want.command_valid,
						want.command_index, want.command_byte, want.packet_done,
						want.framer_mode);
					$display("    actual   rv=%0d rb=%h cv=%0d ci=%0d cb=%h done=%0d mode=%0d",
						got.reply_valid, got.reply_byte, got.command_valid,
						got.command_index, got.command_byte, got.packet_done,
						got.framer_mode);
				end
			end
		endfunction

		function int pending();
			return framing_results_q.size();
		endfunction

		function int failures();
			return n_errors + framing_results_q.size();
		endfunction
	endclass

endpackage

// ===== dv/spi_slave_start_byte_packet_framer_tb.sv =====
// Testbench top for the SPI slave start-byte packet framer: drives requests, start-code writes
// and result back-pressure, and checks every result against framing_scoreboard_pkg.
// Depends on sspf_pkg, framing_scoreboard_pkg and the framer RTL.
`timescale 1ns / 1ps

module spi_slave_start_byte_packet_framer_tb;
	import sspf_pkg::*;
	import framing_scoreboard_pkg::*;

	// Index with no register behind it: a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int  N_PHASES   = 5;
	localparam int  PHASE_REQS = 185;
	localparam int  DIRECTED   = 25;
	localparam real TIMEOUT_NS = 4_000_000.0;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic                  first_of_transfer;
	logic [BYTE_W-1:0]     data_byte;
	logic [BUF_ADDR_W-1:0] load_index;
	logic                  out_valid;
	logic                  out_ready;
	logic                  reply_valid;
	logic [BYTE_W-1:0]     reply_byte;
	logic                  command_valid;
	logic [CMD_IDX_W-1:0]  command_index;
	logic [BYTE_W-1:0]     command_byte;
	logic                  packet_done;
	logic [1:0]            framer_mode;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [BYTE_W-1:0]     cfg_data;

	framing_scoreboard sb;
	int                burst_left;
	int                n_settings;

	spi_slave_start_byte_packet_framer u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.first_of_transfer (first_of_transfer),
		.data_byte         (data_byte),
		.load_index        (load_index),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.reply_valid       (reply_valid),
		.reply_byte        (reply_byte),
		.command_valid     (command_valid),
		.command_index     (command_index),
		.command_byte      (command_byte),
		.packet_done       (packet_done),
		.framer_mode       (framer_mode),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Present one request at the falling edge and hold it until the block takes it.
	// Leave valid high afterwards: the caller either follows with the next request
	// or drops valid for a gap.
	task automatic send_request(framer_request_t rq);
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= rq.op;
		first_of_transfer <= rq.first;
		data_byte <= rq.data;
		load_index <= rq.load_index;
		do @(posedge clk); while (!in_ready);
		sb.predict_framing(rq);
	endtask

	// Drop valid for a number of cycles.
	task automatic idle_gap(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Sender pacing: bursts of random length, a random gap (often none) between bursts.
	task automatic offer(framer_request_t rq);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) idle_gap(gap);
		end
		burst_left--;
		send_request(rq);
	endtask

	task automatic send_load(logic [BUF_ADDR_W-1:0] slot, logic [BYTE_W-1:0] value);
		framer_request_t rq;
		rq.op = OP_LOAD;
		rq.first = 1'($urandom_range(0, 1));
		rq.data = value;
		rq.load_index = slot;
		offer(rq);
	endtask

	// An SPI byte that would read a never-loaded buffer entry gets that entry loaded first,
	// so readouts only ever return written data.
	task automatic send_spi(logic first, logic [BYTE_W-1:0] value);
		framer_request_t rq;
		int              slot;
		rq.op = OP_SPI;
		rq.first = first;
		rq.data = value;
		rq.load_index = BUF_ADDR_W'($urandom_range(0, BUF_DEPTH - 1));
		slot = sb.readout_slot(rq);
		if (slot >= 0 && !sb.loaded[slot])
			send_load(BUF_ADDR_W'(slot), BYTE_W'($urandom_range(0, 255)));
		offer(rq);
	endtask

	// One chip-select transfer: a lead byte, then continuation bytes, with the odd
	// buffer load slipped in between.
	task automatic run_transfer(logic [BYTE_W-1:0] lead, int count);
		send_spi(1'b1, lead);
		repeat (count) begin
			if ($urandom_range(0, 19) == 0)
				send_load(BUF_ADDR_W'($urandom_range(0, BUF_DEPTH - 1)),
					BYTE_W'($urandom_range(0, 255)));
			send_spi(1'b0, BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	// Drop valid and hold off until every predicted result has drained, then allow a little margin.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_code(index, value);
	endtask

	// Short directed pass under the reset start codes: buffer extremes, ignored bytes,
	// a load inside a packet, readout, and a mid-transfer restart.
	task automatic directed_requests();
		send_load('0, 8'hFF);
		send_load('1, 8'h00);
		send_load(BUF_ADDR_W'(1), 8'h5A);
		send_spi(1'b0, RX_CODE_RST);      // continuation while idle: ignored
		send_spi(1'b1, 8'h00);            // unknown lead byte: stay idle
		send_spi(1'b1, RX_CODE_RST);      // start capture, index 0
		send_spi(1'b0, 8'hFF);
		send_spi(1'b0, 8'h00);
		send_load(BUF_ADDR_W'(256), 8'h81); // load leaves the mode alone
		send_spi(1'b0, 8'hA5);
		send_spi(1'b1, TX_CODE_RST);      // start readout from slot 0
		send_spi(1'b0, 8'h00);
		send_spi(1'b0, 8'hFF);
		send_spi(1'b1, RX_CODE_RST);      // restart mid-readout into capture
		send_spi(1'b0, TX_CODE_RST);      // start code as plain payload
		send_spi(1'b1, 8'hFF);            // back to idle
		send_spi(1'b0, 8'h42);
	endtask

	// One random chunk of traffic under the current start codes. Force one full command
	// packet so the packet wrap-up path is reached.
	task automatic random_chunk(int phase);
		int pick;
		int count;
		pick = $urandom_range(0, 99);
		if (sb.n_packets == 0 && phase >= 1) begin
			run_transfer(sb.rx_code, $urandom_range(COMMAND_LENGTH - 1, COMMAND_LENGTH + 6));
		end else if (pick < 8) begin
			// stray continuation bytes
			repeat ($urandom_range(1, 3)) send_spi(1'b0, BYTE_W'($urandom_range(0, 255)));
		end else if (pick < 18) begin
			repeat ($urandom_range(1, 6))
				send_load(BUF_ADDR_W'($urandom_range(0, BUF_DEPTH - 1)),
					BYTE_W'($urandom_range(0, 255)));
		end else if (pick < 55) begin
			count = ($urandom_range(0, 9) == 0) ?
				$urandom_range(COMMAND_LENGTH - 2, COMMAND_LENGTH + 4) : $urandom_range(0, 20);
			run_transfer(sb.rx_code, count);
		end else if (pick < 85) begin
			run_transfer(sb.tx_code, $urandom_range(0, 24));
		end else begin
			run_transfer(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3));
		end
	endtask

	// Result side: sample completed handshakes at the rising edge.
	always @(posedge clk) begin : result_monitor
		framer_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {reply_valid, reply_byte, command_valid, command_index, command_byte,
				packet_done, framer_mode};
			sb.check_result(got);
		end
	end

	// Receiver back-pressure: rotate between always ready, random stalls and a fixed
	// pattern; once, hold off for a long stretch so the block fills and stalls requests.
	initial begin : receiver
		int cyc;
		int hold_left;
		bit held;
		cyc = 0;
		hold_left = 0;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && sb.n_results >= 150) begin
				held = 1'b1;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 256) % 3)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					default: out_ready <= ((cyc % 5) != 0) && ((cyc % 7) != 3);
				endcase
			end
		end
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("[%0t] timeout: results still outstanding or requests stuck", $time);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [BYTE_W-1:0] rx_set [N_PHASES];
		logic [BYTE_W-1:0] tx_set [N_PHASES];
		logic [BYTE_W-1:0] same;
		int                phase_end;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_SPI;
		first_of_transfer = 1'b0;
		data_byte = '0;
		load_index = '0;
		cfg_we = 1'b0;
		cfg_index = REG_RX_CODE;
		cfg_data = '0;
		burst_left = 0;
		n_settings = 1;
		sb = new();

		// Start-code settings: both extremes each way, equal codes (capture wins),
		// random codes, then back to the reset codes.
		same = BYTE_W'($urandom_range(0, 255));
		rx_set = '{8'h00, 8'hFF, same, BYTE_W'($urandom_range(0, 255)), RX_CODE_RST};
		tx_set = '{8'hFF, 8'h00, same, BYTE_W'($urandom_range(0, 255)), TX_CODE_RST};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		directed_requests();

		for (int p = 0; p < N_PHASES; p++) begin
			quiesce();
			write_reg(REG_RX_CODE, rx_set[p]);
			write_reg(REG_TX_CODE, tx_set[p]);
			if (p == 1) write_reg(REG_UNUSED, 8'hA5);
			n_settings++;
			phase_end = DIRECTED + PHASE_REQS * (p + 1);
			if (phase_end < sb.n_requests + 60) phase_end = sb.n_requests + 60;
			while (sb.n_requests < phase_end) random_chunk(p);
		end

		quiesce();

		$display("Covered %0d requests (%0d buffer loads) under %0d start-code settings.",
			sb.n_requests, sb.n_loads, n_settings);
		$display("Checked %0d results: %0d command bytes, %0d full packets, %0d replies, %0d %s",
			sb.n_results, sb.n_commands, sb.n_packets, sb.n_replies, sb.n_readouts,
			"full readouts");
		if (sb.failures() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures, %0d results never arrived", sb.failures(), sb.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
